// ===== rtl/u2s_pkg.sv =====
// ============================================================================
// u2s_pkg
// Shared types and constants of the UTF-8 to UCS-2 speech frame builder.
// ============================================================================
`default_nettype none

package u2s_pkg;

    // Command fields are sized for the largest unit store the block supports.
    localparam int UNIT_CNT_W  = 5;
    localparam int QUEUE_DEPTH = 4;
    localparam int QUEUE_AW    = 2;
    localparam int QUEUE_CW    = 3;

    localparam int APB_AW = 4;
    localparam int APB_DW = 32;

    // Register indexes (byte address = 4 * index)
    localparam logic [1:0] REG_HEAD    = 2'd0;
    localparam logic [1:0] REG_COMMAND = 2'd1;
    localparam logic [1:0] REG_PARAM   = 2'd2;

    localparam logic [7:0] HEAD_RESET    = 8'hFD;
    localparam logic [7:0] COMMAND_RESET = 8'h01;
    localparam logic [7:0] PARAM_RESET   = 8'h03;

    localparam logic [7:0] ASCII_MAX  = 8'h7F;
    localparam logic [7:0] LEAD2_MASK = 8'hE0;
    localparam logic [7:0] LEAD2_CODE = 8'hC0;
    localparam logic [7:0] LEAD3_MASK = 8'hF0;
    localparam logic [7:0] LEAD3_CODE = 8'hE0;
    localparam logic [7:0] CONT_MASK  = 8'hC0;
    localparam logic [7:0] CONT_CODE  = 8'h80;

    typedef enum logic [1:0] {
        PH_LEAD,
        PH_TWO_LAST,
        PH_THREE_MID,
        PH_THREE_LAST
    } t_phase;

    typedef enum logic [3:0] {
        ES_IDLE,
        ES_HEAD,
        ES_LEN_HI,
        ES_LEN_LO,
        ES_COMMAND,
        ES_PARAM,
        ES_UNIT_HI,
        ES_UNIT_LO,
        ES_SUM
    } t_emit_state;

    // One entry between decoder and frame builder: an optional unit write
    // and, on the last text byte, the frame request.
    typedef struct packed {
        logic                  unit_valid;
        logic [15:0]           unit;
        logic [UNIT_CNT_W-1:0] addr;
        logic                  is_end;
        logic                  bad;
        logic                  too_long;
        logic [UNIT_CNT_W-1:0] units;
    } t_cmd;

    typedef struct packed {
        logic [7:0] head;
        logic [7:0] command;
        logic [7:0] param;
    } t_cfg;

endpackage

`default_nettype wire

// ===== rtl/u2s_in_if.sv =====
// ============================================================================
// u2s_in_if
// Text byte channel: valid/ready handshake with one UTF-8 byte per item.
// ============================================================================
`default_nettype none

interface u2s_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] text_byte;
    logic       text_end;

    modport source (output valid, output text_byte, output text_end, input ready);
    modport sink   (input valid, input text_byte, input text_end, output ready);
endinterface

`default_nettype wire

// ===== rtl/u2s_out_if.sv =====
// ============================================================================
// u2s_out_if
// Frame byte channel: valid/ready handshake with one frame byte per item.
// ============================================================================
`default_nettype none

interface u2s_out_if;
    logic       valid;
    logic       ready;
    logic [7:0] frame_byte;
    logic       frame_last;
    logic       bad_text;
    logic       text_too_long;

    modport source (output valid, output frame_byte, output frame_last,
                    output bad_text, output text_too_long, input ready);
    modport sink   (input valid, input frame_byte, input frame_last,
                    input bad_text, input text_too_long, output ready);
endinterface

`default_nettype wire

// ===== rtl/utf8_to_ucs2_speech_frame.sv =====
// ============================================================================
// utf8_to_ucs2_speech_frame
// UTF-8 text to UCS-2 speech command frame builder with APB register port.
// ============================================================================
// Text bytes: one per cycle while the 4-entry command queue has room.
// Frame: the last text byte's request is queued, taken by the idle sequencer,
//   then 6 + 2*units bytes go out, one per cycle while o_frame is ready.
// Bytes of the next text keep flowing until the queue fills behind a frame.
// Reset (synchronous, active low) clears decoder, queue and sequencer;
//   registers return to head 0xFD, command 0x01, parameter 0x03.
`default_nettype none

module utf8_to_ucs2_speech_frame #(
    parameter int MAX_UNITS = 29
) (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    u2s_in_if.sink                             i_text,
    u2s_out_if.source                          o_frame,
    input  wire logic                          psel,
    input  wire logic                          penable,
    input  wire logic                          pwrite,
    input  wire logic [u2s_pkg::APB_AW-1:0]    paddr,
    input  wire logic [u2s_pkg::APB_DW-1:0]    pwdata,
    output logic      [u2s_pkg::APB_DW-1:0]    prdata,
    output logic                               pready
);

    u2s_pkg::t_cfg r_cfg;
    u2s_pkg::t_cmd w_front_cmd;
    u2s_pkg::t_cmd w_back_cmd;
    logic          w_front_valid;
    logic          w_front_ready;
    logic          w_back_valid;
    logic          w_back_ready;
    logic          w_wr;

    assign pready = 1'b1;
    assign w_wr   = psel && penable && pwrite;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.head    <= u2s_pkg::HEAD_RESET;
            r_cfg.command <= u2s_pkg::COMMAND_RESET;
            r_cfg.param   <= u2s_pkg::PARAM_RESET;
        end else if (w_wr) begin
            case (paddr[3:2])
                u2s_pkg::REG_HEAD:    r_cfg.head    <= pwdata[7:0];
                u2s_pkg::REG_COMMAND: r_cfg.command <= pwdata[7:0];
                u2s_pkg::REG_PARAM:   r_cfg.param   <= pwdata[7:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (paddr[3:2])
            u2s_pkg::REG_HEAD:    prdata = {24'd0, r_cfg.head};
            u2s_pkg::REG_COMMAND: prdata = {24'd0, r_cfg.command};
            u2s_pkg::REG_PARAM:   prdata = {24'd0, r_cfg.param};
            default:              prdata = '0;
        endcase
    end

    u2s_front #(
        .MAX_UNITS (MAX_UNITS)
    ) u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_text      (i_text),
        .o_cmd       (w_front_cmd),
        .o_cmd_valid (w_front_valid),
        .i_cmd_ready (w_front_ready)
    );

    u2s_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cmd   (w_front_cmd),
        .i_valid (w_front_valid),
        .o_ready (w_front_ready),
        .o_cmd   (w_back_cmd),
        .o_valid (w_back_valid),
        .i_ready (w_back_ready)
    );

    u2s_back #(
        .MAX_UNITS (MAX_UNITS)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg       (r_cfg),
        .i_cmd       (w_back_cmd),
        .i_cmd_valid (w_back_valid),
        .o_cmd_ready (w_back_ready),
        .o_frame     (o_frame)
    );

endmodule

`default_nettype wire

// ===== rtl/u2s_front.sv =====
// ============================================================================
// u2s_front
// UTF-8 decoder: classifies each text byte, tracks errors and unit count,
// and issues unit writes and frame requests to the queue.
// ============================================================================
`default_nettype none

module u2s_front #(
    parameter int MAX_UNITS = 29
) (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    u2s_in_if.sink             i_text,
    output u2s_pkg::t_cmd      o_cmd,
    output logic               o_cmd_valid,
    input  wire logic          i_cmd_ready
);

    localparam int CW = $clog2(MAX_UNITS + 1);

    u2s_pkg::t_phase r_phase, n_phase;
    logic [7:0]      r_lead, n_lead;
    logic [7:0]      r_mid, n_mid;
    logic [CW-1:0]   r_count, n_count;
    logic            r_bad, n_bad;
    logic            r_long, n_long;
    logic            r_ended, n_ended;

    logic            w_push;
    logic [15:0]     w_unit;
    logic [7:0]      w_b;
    logic            w_accept;

    assign w_b         = i_text.text_byte;
    assign i_text.ready = i_cmd_ready;
    assign w_accept    = i_text.valid && i_cmd_ready;

    always_comb begin
        n_phase = r_phase;
        n_lead  = r_lead;
        n_mid   = r_mid;
        n_count = r_count;
        n_bad   = r_bad;
        n_long  = r_long;
        n_ended = r_ended;
        w_push  = 1'b0;
        w_unit  = 16'd0;
        o_cmd   = '0;

        if (!r_ended && !r_bad) begin
            case (r_phase)
                u2s_pkg::PH_LEAD: begin
                    if (w_b == 8'd0) begin
                        n_ended = 1'b1;
                    end else if (w_b <= u2s_pkg::ASCII_MAX) begin
                        w_push = 1'b1;
                        w_unit = {8'd0, w_b};
                    end else if ((w_b & u2s_pkg::LEAD2_MASK) == u2s_pkg::LEAD2_CODE) begin
                        n_lead  = w_b;
                        n_phase = u2s_pkg::PH_TWO_LAST;
                    end else if ((w_b & u2s_pkg::LEAD3_MASK) == u2s_pkg::LEAD3_CODE) begin
                        n_lead  = w_b;
                        n_phase = u2s_pkg::PH_THREE_MID;
                    end else begin
                        n_bad = 1'b1;
                    end
                end
                u2s_pkg::PH_TWO_LAST: begin
                    n_phase = u2s_pkg::PH_LEAD;
                    if ((w_b & u2s_pkg::CONT_MASK) != u2s_pkg::CONT_CODE) begin
                        n_bad = 1'b1;
                    end else begin
                        w_push = 1'b1;
                        w_unit = {5'd0, r_lead[4:0], w_b[5:0]};
                    end
                end
                u2s_pkg::PH_THREE_MID: begin
                    if ((w_b & u2s_pkg::CONT_MASK) != u2s_pkg::CONT_CODE) begin
                        n_bad   = 1'b1;
                        n_phase = u2s_pkg::PH_LEAD;
                    end else begin
                        n_mid   = w_b;
                        n_phase = u2s_pkg::PH_THREE_LAST;
                    end
                end
                default: begin
                    n_phase = u2s_pkg::PH_LEAD;
                    if ((w_b & u2s_pkg::CONT_MASK) != u2s_pkg::CONT_CODE) begin
                        n_bad = 1'b1;
                    end else begin
                        w_push = 1'b1;
                        w_unit = {r_lead[3:0], r_mid[5:0], w_b[5:0]};
                    end
                end
            endcase
        end

        if (w_push) begin
            if (r_count < CW'(MAX_UNITS)) begin
                o_cmd.unit_valid = 1'b1;
                o_cmd.unit       = w_unit;
                o_cmd.addr       = u2s_pkg::UNIT_CNT_W'(r_count);
                n_count          = CW'(r_count + 1'b1);
            end else begin
                n_long = 1'b1;
            end
        end

        if (i_text.text_end) begin
            // sequence still open at the end of the text
            if (n_phase != u2s_pkg::PH_LEAD) begin
                n_bad = 1'b1;
            end
            o_cmd.is_end   = 1'b1;
            o_cmd.bad      = n_bad;
            o_cmd.too_long = n_long;
            o_cmd.units    = (n_bad || n_long) ? '0 : u2s_pkg::UNIT_CNT_W'(n_count);
            n_phase = u2s_pkg::PH_LEAD;
            n_lead  = 8'd0;
            n_mid   = 8'd0;
            n_count = '0;
            n_bad   = 1'b0;
            n_long  = 1'b0;
            n_ended = 1'b0;
        end

        o_cmd_valid = i_text.valid && (o_cmd.unit_valid || o_cmd.is_end);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= u2s_pkg::PH_LEAD;
            r_lead  <= 8'd0;
            r_mid   <= 8'd0;
            r_count <= '0;
            r_bad   <= 1'b0;
            r_long  <= 1'b0;
            r_ended <= 1'b0;
        end else if (w_accept) begin
            r_phase <= n_phase;
            r_lead  <= n_lead;
            r_mid   <= n_mid;
            r_count <= n_count;
            r_bad   <= n_bad;
            r_long  <= n_long;
            r_ended <= n_ended;
        end
    end

endmodule

`default_nettype wire

// ===== rtl/u2s_queue.sv =====
// ============================================================================
// u2s_queue
// Small FIFO of decoder commands between the decoder and the frame builder.
// ============================================================================
`default_nettype none

module u2s_queue (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire u2s_pkg::t_cmd  i_cmd,
    input  wire logic           i_valid,
    output logic                o_ready,
    output u2s_pkg::t_cmd       o_cmd,
    output logic                o_valid,
    input  wire logic           i_ready
);

    u2s_pkg::t_cmd                   r_mem [u2s_pkg::QUEUE_DEPTH];
    logic [u2s_pkg::QUEUE_AW-1:0]    r_wr_ptr;
    logic [u2s_pkg::QUEUE_AW-1:0]    r_rd_ptr;
    logic [u2s_pkg::QUEUE_CW-1:0]    r_fill;
    logic                            w_push;
    logic                            w_pop;

    assign o_ready = (r_fill != u2s_pkg::QUEUE_CW'(u2s_pkg::QUEUE_DEPTH));
    assign o_valid = (r_fill != '0);
    assign o_cmd   = r_mem[r_rd_ptr];
    assign w_push  = i_valid && o_ready;
    assign w_pop   = o_valid && i_ready;

    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_mem[r_wr_ptr] <= i_cmd;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_fill   <= '0;
        end else begin
            if (w_push) begin
                r_wr_ptr <= r_wr_ptr + 1'b1;
            end
            if (w_pop) begin
                r_rd_ptr <= r_rd_ptr + 1'b1;
            end
            case ({w_push, w_pop})
                2'b10:   r_fill <= r_fill + 1'b1;
                2'b01:   r_fill <= r_fill - 1'b1;
                default: r_fill <= r_fill;
            endcase
        end
    end

endmodule

`default_nettype wire

// ===== rtl/u2s_back.sv =====
// ============================================================================
// u2s_back
// Frame builder: owns the unit store; on a frame request sends head, length,
// command, parameter, unit bytes and XOR checksum, one byte a cycle if ready.
// ============================================================================
`default_nettype none

module u2s_back #(
    parameter int MAX_UNITS = 29
) (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire u2s_pkg::t_cfg  i_cfg,
    input  wire u2s_pkg::t_cmd  i_cmd,
    input  wire logic           i_cmd_valid,
    output logic                o_cmd_ready,
    u2s_out_if.source           o_frame
);

    localparam int CW = $clog2(MAX_UNITS + 1);
    localparam int IW = (MAX_UNITS > 1) ? $clog2(MAX_UNITS) : 1;

    u2s_pkg::t_emit_state r_state, n_state;
    logic [IW-1:0]        r_idx, n_idx;
    logic [CW-1:0]        r_units, n_units;
    logic                 r_bad, n_bad;
    logic                 r_long, n_long;
    logic [7:0]           r_sum, n_sum;

    logic [15:0]          r_store [MAX_UNITS];
    logic [15:0]          r_rd;

    logic                 r_out_valid;
    logic [7:0]           r_out_byte;
    logic                 r_out_last;
    logic                 r_out_bad;
    logic                 r_out_long;

    logic                 w_load;
    logic                 w_emit;
    logic [7:0]           w_byte;
    logic                 w_last;
    logic                 w_rd_en;
    logic [IW-1:0]        w_rd_addr;
    logic [15:0]          w_len;
    logic [CW-1:0]        w_idx_inc;

    assign w_load    = !r_out_valid || o_frame.ready;
    assign w_len     = 16'({r_units, 1'b0}) + 16'd3;
    assign w_idx_inc = CW'(r_idx) + CW'(1);

    always_comb begin
        n_state     = r_state;
        n_idx       = r_idx;
        n_units     = r_units;
        n_bad       = r_bad;
        n_long      = r_long;
        n_sum       = r_sum;
        o_cmd_ready = 1'b0;
        w_emit      = 1'b0;
        w_byte      = 8'd0;
        w_last      = 1'b0;
        w_rd_en     = 1'b0;
        w_rd_addr   = '0;

        case (r_state)
            u2s_pkg::ES_IDLE: begin
                o_cmd_ready = 1'b1;
                if (i_cmd_valid && i_cmd.is_end) begin
                    n_state = u2s_pkg::ES_HEAD;
                    n_units = i_cmd.units[CW-1:0];
                    n_bad   = i_cmd.bad;
                    n_long  = i_cmd.too_long;
                    n_sum   = 8'd0;
                    n_idx   = '0;
                end
            end
            u2s_pkg::ES_HEAD: begin
                w_byte = i_cfg.head;
                if (w_load) begin
                    w_emit  = 1'b1;
                    n_state = u2s_pkg::ES_LEN_HI;
                end
            end
            u2s_pkg::ES_LEN_HI: begin
                w_byte = w_len[15:8];
                if (w_load) begin
                    w_emit  = 1'b1;
                    n_state = u2s_pkg::ES_LEN_LO;
                end
            end
            u2s_pkg::ES_LEN_LO: begin
                w_byte = w_len[7:0];
                if (w_load) begin
                    w_emit  = 1'b1;
                    n_state = u2s_pkg::ES_COMMAND;
                end
            end
            u2s_pkg::ES_COMMAND: begin
                w_byte = i_cfg.command;
                if (w_load) begin
                    w_emit  = 1'b1;
                    n_state = u2s_pkg::ES_PARAM;
                end
            end
            u2s_pkg::ES_PARAM: begin
                w_byte = i_cfg.param;
                if (w_load) begin
                    w_emit  = 1'b1;
                    // fetch the first unit ahead of its high byte
                    w_rd_en = (r_units != '0);
                    n_state = (r_units != '0) ? u2s_pkg::ES_UNIT_HI : u2s_pkg::ES_SUM;
                end
            end
            u2s_pkg::ES_UNIT_HI: begin
                w_byte = r_rd[15:8];
                if (w_load) begin
                    w_emit  = 1'b1;
                    n_state = u2s_pkg::ES_UNIT_LO;
                end
            end
            u2s_pkg::ES_UNIT_LO: begin
                w_byte = r_rd[7:0];
                if (w_load) begin
                    w_emit = 1'b1;
                    if (w_idx_inc == r_units) begin
                        n_state = u2s_pkg::ES_SUM;
                    end else begin
                        n_idx     = IW'(w_idx_inc);
                        w_rd_en   = 1'b1;
                        w_rd_addr = IW'(w_idx_inc);
                        n_state   = u2s_pkg::ES_UNIT_HI;
                    end
                end
            end
            u2s_pkg::ES_SUM: begin
                w_byte = r_sum;
                w_last = 1'b1;
                if (w_load) begin
                    w_emit  = 1'b1;
                    n_state = u2s_pkg::ES_IDLE;
                end
            end
            default: begin
                n_state = u2s_pkg::ES_IDLE;
            end
        endcase

        if (w_emit) begin
            n_sum = r_sum ^ w_byte;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= u2s_pkg::ES_IDLE;
            r_idx   <= '0;
            r_units <= '0;
            r_bad   <= 1'b0;
            r_long  <= 1'b0;
            r_sum   <= 8'd0;
        end else begin
            r_state <= n_state;
            r_idx   <= n_idx;
            r_units <= n_units;
            r_bad   <= n_bad;
            r_long  <= n_long;
            r_sum   <= n_sum;
        end
    end

    // unit store: written from the queue while idle, read during a frame
    always_ff @(posedge i_clk) begin
        if (r_state == u2s_pkg::ES_IDLE && i_cmd_valid && i_cmd.unit_valid) begin
            r_store[i_cmd.addr[IW-1:0]] <= i_cmd.unit;
        end
        if (w_rd_en) begin
            r_rd <= r_store[w_rd_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_emit) begin
            r_out_valid <= 1'b1;
        end else if (o_frame.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_emit) begin
            r_out_byte <= w_byte;
            r_out_last <= w_last;
            r_out_bad  <= r_bad;
            r_out_long <= r_long;
        end
    end

    assign o_frame.valid         = r_out_valid;
    assign o_frame.frame_byte    = r_out_byte;
    assign o_frame.frame_last    = r_out_last;
    assign o_frame.bad_text      = r_out_bad;
    assign o_frame.text_too_long = r_out_long;

endmodule

`default_nettype wire
